// ----- hw/rtl/ssra_pkg.sv -----
`default_nettype none
package ssra_pkg;

  // fixed field widths
  localparam int SLOTS      = 4;
  localparam int ENTRY_W    = 63;
  localparam int TEMP_W     = 11;
  localparam int HOUR_W     = 5;
  localparam int MIN_W      = 6;
  localparam int ELAPSED_W  = 16;
  localparam int TIMER_W    = 24;
  localparam int RAMP_MIN_W = 8;
  localparam int COUNT_W    = 3;
  localparam int SEL_W      = 2;
  localparam int CFG_IDX_W  = 3;

  // packed entry layout
  localparam int HOUR_LSB       = 0;
  localparam int MIN_LSB        = 5;
  localparam int COOL_SUN_LSB   = 11;
  localparam int HEAT_SUN_LSB   = 22;
  localparam int COOL_CLOUD_LSB = 33;
  localparam int HEAT_CLOUD_LSB = 44;
  localparam int RAMP_LSB       = 55;

  localparam logic [ELAPSED_W-1:0] MS_PER_MINUTE = 16'd60000;
  localparam logic signed [TEMP_W:0] RAMP_STEP   = 12'sd5;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_ZERO  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_ONE   = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_TWO   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_THREE = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENTRY_COUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_LOW   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_HIGH  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_ALARM_ON    = 3'd7;

  // request queue geometry
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;
  localparam int QCNT_W      = 2;

  typedef logic signed [TEMP_W-1:0] temp_t;

  typedef struct packed {
    logic [SLOTS-1:0][ENTRY_W-1:0] entry;
    logic [COUNT_W-1:0]            count;
    temp_t                         alarm_low;
    temp_t                         alarm_high;
    logic                          alarm_on;
  } cfg_t;

  // classified request handed from front to back
  typedef struct packed {
    logic                 hit;
    logic [SEL_W-1:0]     hit_idx;
    logic                 cloudy;
    logic                 alarm_upd;
    logic                 alarm_set;
    logic [ELAPSED_W-1:0] elapsed;
  } item_t;

  // one RAMP_STEP step toward the goal, never past it
  function automatic temp_t move_toward(input temp_t level, input temp_t goal);
    logic signed [TEMP_W:0] lvl_x;
    logic signed [TEMP_W:0] goal_x;
    logic signed [TEMP_W:0] up;
    logic signed [TEMP_W:0] dn;
    temp_t                  res;
    lvl_x  = {level[TEMP_W-1], level};
    goal_x = {goal[TEMP_W-1], goal};
    up     = lvl_x + RAMP_STEP;
    dn     = lvl_x - RAMP_STEP;
    res    = level;
    if (goal_x > lvl_x) begin
      res = (up > goal_x) ? goal : up[TEMP_W-1:0];
    end else if (goal_x < lvl_x) begin
      res = (dn < goal_x) ? goal : dn[TEMP_W-1:0];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/ssra_front.sv -----
`default_nettype none
module ssra_front #(
  parameter int ENTRIES = 4
) (
  input  ssra_pkg::cfg_t                      cfg,
  input  logic [ssra_pkg::HOUR_W-1:0]         hour_now,
  input  logic [ssra_pkg::MIN_W-1:0]          minute_now,
  input  logic                                cloudy,
  input  logic signed [ssra_pkg::TEMP_W-1:0]  air_temp,
  input  logic [ssra_pkg::ELAPSED_W-1:0]      elapsed_ms,
  output ssra_pkg::item_t                     item
);
  import ssra_pkg::*;

  localparam int LIMIT = (ENTRIES < SLOTS) ? ENTRIES : SLOTS;
  localparam logic [COUNT_W-1:0] LIMIT_CNT = COUNT_W'(LIMIT);

  logic [SLOTS-1:0][HOUR_W-1:0] eff_hr;
  logic [SLOTS-1:0][MIN_W-1:0]  eff_mn;
  logic [COUNT_W-1:0]           n_use;
  logic [SEL_W-1:0]             last;
  logic                         hit;
  logic [SEL_W-1:0]             hit_idx;

  // effective start times as a running maximum
  always_comb begin
    eff_hr[0] = cfg.entry[0][HOUR_LSB +: HOUR_W];
    eff_mn[0] = cfg.entry[0][MIN_LSB +: MIN_W];
    for (int y = 1; y < SLOTS; y++) begin
      eff_hr[y] = cfg.entry[y][HOUR_LSB +: HOUR_W];
      eff_mn[y] = cfg.entry[y][MIN_LSB +: MIN_W];
      if (eff_hr[y] < eff_hr[y-1] ||
          (eff_hr[y] == eff_hr[y-1] && eff_mn[y] < eff_mn[y-1])) begin
        eff_hr[y] = eff_hr[y-1];
        eff_mn[y] = eff_mn[y-1];
      end
    end
  end

  // entries in use, clamped
  always_comb begin
    n_use = cfg.count;
    if (n_use == '0) n_use = COUNT_W'(1);
    if (n_use > LIMIT_CNT) n_use = LIMIT_CNT;
    last = SEL_W'(n_use - COUNT_W'(1));
  end

  // window match, later matches win
  always_comb begin
    hit     = 1'b0;
    hit_idx = '0;
    for (int y = 0; y < SLOTS - 1; y++) begin
      if (COUNT_W'(y + 1) < n_use &&
          ((hour_now == eff_hr[y] && minute_now >= eff_mn[y]) ||
           (hour_now > eff_hr[y] && hour_now < eff_hr[y+1]) ||
           (hour_now == eff_hr[y+1] && minute_now < eff_mn[y+1]))) begin
        hit     = 1'b1;
        hit_idx = SEL_W'(y);
      end
    end
    if ((hour_now == eff_hr[last] && minute_now >= eff_mn[last]) ||
        hour_now > eff_hr[last] || hour_now < eff_hr[0] ||
        (hour_now == eff_hr[0] && minute_now < eff_mn[0])) begin
      hit     = 1'b1;
      hit_idx = last;
    end
  end

  // pack the classified request, alarm window decided here
  always_comb begin
    item.hit       = hit;
    item.hit_idx   = hit_idx;
    item.cloudy    = cloudy;
    item.alarm_upd = cfg.alarm_on;
    item.alarm_set = (air_temp < cfg.alarm_low) || (air_temp > cfg.alarm_high);
    item.elapsed   = elapsed_ms;
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ssra_queue.sv -----
`default_nettype none
module ssra_queue (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            push_valid,
  output logic            push_ready,
  input  ssra_pkg::item_t push_item,
  output logic            pop_valid,
  input  logic            pop,
  output ssra_pkg::item_t pop_item
);
  import ssra_pkg::*;

  item_t             mem_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_r;
  logic [QPTR_W-1:0] rd_ptr_r;
  logic [QCNT_W-1:0] cnt_r;
  logic [QPTR_W-1:0] wr_ptr_nxt;
  logic [QPTR_W-1:0] rd_ptr_nxt;
  logic [QCNT_W-1:0] cnt_nxt;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (cnt_r != QCNT_W'(QUEUE_DEPTH));
  assign pop_valid  = (cnt_r != '0);
  assign pop_item   = mem_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + QPTR_W'(1) : wr_ptr_r;
    rd_ptr_nxt = do_pop  ? rd_ptr_r + QPTR_W'(1) : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) cnt_nxt = cnt_r + QCNT_W'(1);
    if (!do_push && do_pop) cnt_nxt = cnt_r - QCNT_W'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

// ----- hw/rtl/ssra_back.sv -----
`default_nettype none
module ssra_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  ssra_pkg::cfg_t                     cfg,
  input  logic                               q_valid,
  input  ssra_pkg::item_t                    q_item,
  output logic                               q_pop,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic signed [ssra_pkg::TEMP_W-1:0] out_cooling_setpoint,
  output logic signed [ssra_pkg::TEMP_W-1:0] out_heating_setpoint,
  output logic [ssra_pkg::SEL_W-1:0]         out_active_entry,
  output logic                               out_alarm_active
);
  import ssra_pkg::*;

  // state
  temp_t              cool_r, cool_nxt;
  temp_t              heat_r, heat_nxt;
  logic [SEL_W-1:0]   entry_r, entry_nxt;
  logic [TIMER_W-1:0] timer_r, timer_nxt;
  logic               started_r, started_nxt;
  logic               alarm_r, alarm_nxt;
  logic               out_valid_r, out_valid_nxt;

  // output register payload
  temp_t              out_cool_r;
  temp_t              out_heat_r;
  logic [SEL_W-1:0]   out_entry_r;
  logic               out_alarm_r;

  logic [ENTRY_W-1:0] e;
  temp_t              cool_goal;
  temp_t              heat_goal;
  logic [TIMER_W-1:0] ramp_ms;
  logic [TIMER_W:0]   timer_sum;
  logic [TIMER_W-1:0] timer_sat;
  logic               step;

  assign q_pop = q_valid && (!out_valid_r || out_ready);

  // targets of the selected entry
  always_comb begin
    entry_nxt = q_item.hit ? q_item.hit_idx : entry_r;
    e         = cfg.entry[entry_nxt];
    cool_goal = q_item.cloudy ? e[COOL_CLOUD_LSB +: TEMP_W] : e[COOL_SUN_LSB +: TEMP_W];
    heat_goal = q_item.cloudy ? e[HEAT_CLOUD_LSB +: TEMP_W] : e[HEAT_SUN_LSB +: TEMP_W];
    ramp_ms   = TIMER_W'(e[RAMP_LSB +: RAMP_MIN_W]) * TIMER_W'(MS_PER_MINUTE);
  end

  // saturating ramp timer
  always_comb begin
    timer_sum = {1'b0, timer_r} + (TIMER_W + 1)'(q_item.elapsed);
    timer_sat = timer_sum[TIMER_W] ? '1 : timer_sum[TIMER_W-1:0];
    step      = timer_sat > ramp_ms;
  end

  // setpoint update
  always_comb begin
    cool_nxt    = cool_r;
    heat_nxt    = heat_r;
    timer_nxt   = timer_r;
    started_nxt = 1'b1;
    if (!started_r) begin
      cool_nxt  = cool_goal;
      heat_nxt  = heat_goal;
      timer_nxt = '0;
    end else if (step) begin
      cool_nxt  = move_toward(cool_r, cool_goal);
      heat_nxt  = move_toward(heat_r, heat_goal);
      timer_nxt = '0;
    end else begin
      timer_nxt = timer_sat;
    end
    alarm_nxt = q_item.alarm_upd ? q_item.alarm_set : alarm_r;
  end

  // output register handshake
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (q_pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cool_r      <= '0;
      heat_r      <= '0;
      entry_r     <= '0;
      timer_r     <= '0;
      started_r   <= 1'b0;
      alarm_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (q_pop) begin
        cool_r    <= cool_nxt;
        heat_r    <= heat_nxt;
        entry_r   <= entry_nxt;
        timer_r   <= timer_nxt;
        started_r <= started_nxt;
        alarm_r   <= alarm_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_cool_r  <= cool_nxt;
      out_heat_r  <= heat_nxt;
      out_entry_r <= entry_nxt;
      out_alarm_r <= alarm_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_cooling_setpoint = out_cool_r;
  assign out_heating_setpoint = out_heat_r;
  assign out_active_entry     = out_entry_r;
  assign out_alarm_active     = out_alarm_r;

endmodule
`default_nettype wire

// ----- hw/rtl/scheduled_setpoint_ramp_alarm_top.sv -----
// Scheduled setpoint ramp with temperature alarm.
// Input channel (in_valid/in_ready) takes one request per cycle while
// in_ready is high: time of day, cloudy flag, air temperature and elapsed
// milliseconds. Result channel (out_valid/out_ready) returns one request
// per input: cooling and heating setpoints, active schedule entry and alarm flag.
// The front classifies a request in the accept cycle (schedule window
// match, alarm window) and writes it into a two-deep queue; the back pops
// the queue, applies the setpoint ramp and loads the output register.
// A request is written into the queue and then popped into the output
// register. Throughput: 1 request per cycle while out_ready is high, set
// by the state update in the back. When out_ready is low the output
// register holds, the back stops popping and the queue absorbs up to two
// more requests before in_ready drops.
// Reset (rst_n low, synchronous) empties the queue and the output
// register and restores register defaults; the first request after reset
// loads setpoints straight from the selected targets.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once;
// the user must make them only while no request is in flight; not enforced.
`default_nettype none
module scheduled_setpoint_ramp_alarm_top #(
  parameter int ENTRIES = 4
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [ssra_pkg::HOUR_W-1:0]         in_hour_now,
  input  logic [ssra_pkg::MIN_W-1:0]          in_minute_now,
  input  logic                                in_cloudy,
  input  logic signed [ssra_pkg::TEMP_W-1:0]  in_air_temp,
  input  logic [ssra_pkg::ELAPSED_W-1:0]      in_elapsed_ms,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [ssra_pkg::TEMP_W-1:0]  out_cooling_setpoint,
  output logic signed [ssra_pkg::TEMP_W-1:0]  out_heating_setpoint,
  output logic [ssra_pkg::SEL_W-1:0]          out_active_entry,
  output logic                                out_alarm_active,
  input  logic                                cfg_we,
  input  logic [ssra_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [ssra_pkg::ENTRY_W-1:0]        cfg_wdata
);
  import ssra_pkg::*;

  cfg_t  cfg_r;
  item_t front_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.entry      <= '0;
      cfg_r.count      <= COUNT_W'(1);
      cfg_r.alarm_low  <= TEMP_W'(0);
      cfg_r.alarm_high <= TEMP_W'(1000);
      cfg_r.alarm_on   <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_ENTRY_ZERO:  cfg_r.entry[0]   <= cfg_wdata;
        REG_ENTRY_ONE:   cfg_r.entry[1]   <= cfg_wdata;
        REG_ENTRY_TWO:   cfg_r.entry[2]   <= cfg_wdata;
        REG_ENTRY_THREE: cfg_r.entry[3]   <= cfg_wdata;
        REG_ENTRY_COUNT: cfg_r.count      <= cfg_wdata[COUNT_W-1:0];
        REG_ALARM_LOW:   cfg_r.alarm_low  <= cfg_wdata[TEMP_W-1:0];
        REG_ALARM_HIGH:  cfg_r.alarm_high <= cfg_wdata[TEMP_W-1:0];
        REG_ALARM_ON:    cfg_r.alarm_on   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // request classification
  ssra_front #(
    .ENTRIES (ENTRIES)
  ) u_front (
    .cfg        (cfg_r),
    .hour_now   (in_hour_now),
    .minute_now (in_minute_now),
    .cloudy     (in_cloudy),
    .air_temp   (in_air_temp),
    .elapsed_ms (in_elapsed_ms),
    .item       (front_item)
  );

  // decoupling queue
  ssra_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  // setpoint ramp and output register
  ssra_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .q_valid              (q_valid),
    .q_item               (q_item),
    .q_pop                (q_pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_cooling_setpoint (out_cooling_setpoint),
    .out_heating_setpoint (out_heating_setpoint),
    .out_active_entry     (out_active_entry),
    .out_alarm_active     (out_alarm_active)
  );

`ifndef SYNTHESIS
  // output register empties on reset
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid set right after reset");

  // nothing appears at the output without a queued request
  a_no_invented_result: assert property (@(posedge clk) disable iff (!rst_n)
    (!q_valid && !out_valid) |=> !out_valid)
    else $error("result produced with empty queue");

  // an accepted request that is not popped stays queued
  a_push_lands: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && !q_pop) |=> q_valid)
    else $error("accepted request lost from queue");
`endif

endmodule
`default_nettype wire
